// ----- rtl/imrot_pkg.sv -----
// Shared types and constants for the image rotation block.
// Used by imrot_coord, imrot_store and image_rotate_about_point. No dependencies.

package imrot_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int PIXEL_BITS = 32;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = COL_W + ROW_W;
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;

	// Q2.14 fixed point.
	localparam int Q_FRAC = 14;

	// Command codes.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Register indexes (byte address / 4).
	localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_CENTRE_X        = 3'd2;
	localparam logic [2:0] REG_CENTRE_Y        = 3'd3;
	localparam logic [2:0] REG_COSINE_Q14      = 3'd4;
	localparam logic [2:0] REG_SINE_Q14        = 3'd5;
	localparam logic [2:0] REG_BYTES_PER_PIXEL = 3'd6;

	typedef struct packed {
		logic [8:0]  image_width;
		logic [8:0]  image_height;
		logic [10:0] centre_x;
		logic [10:0] centre_y;
		logic [15:0] cosine_q14;
		logic [15:0] sine_q14;
		logic [2:0]  bytes_per_pixel;
	} cfg_t;

	// One item leaving the coordinate pipeline toward the pixel store.
	typedef struct packed {
		logic                  cmd;
		logic [ADDR_W-1:0]     addr;
		logic                  outside;
		logic [PIXEL_BITS-1:0] pixel;
	} store_req_t;

endpackage

// ----- rtl/imrot_coord.sv -----
// Four-stage coordinate pipeline: offsets, products, sums, truncation and range check.
// Depends on imrot_pkg for the configuration and request types.

module imrot_coord (
	input  logic                             clk,
	input  logic                             arst_n,
	input  imrot_pkg::cfg_t                  cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic [7:0]                       row,
	input  logic [7:0]                       col,
	input  logic [imrot_pkg::PIXEL_BITS-1:0] pixel_in,
	input  logic                             down_ready,
	output logic                             req_valid,
	output imrot_pkg::store_req_t            req
);

	localparam int PROD_W = 28;
	localparam int SUM_W  = 29;
	localparam int SRC_W  = SUM_W - imrot_pkg::Q_FRAC;

	logic en1, en2, en3, en4;

	logic                             v_s1, v_s2, v_s3, v_s4;
	logic                             cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [7:0]                       row_s1, row_s2, row_s3;
	logic [7:0]                       col_s1, col_s2, col_s3;
	logic [imrot_pkg::PIXEL_BITS-1:0] pix_s1, pix_s2, pix_s3, pix_s4;
	logic signed [11:0]               dx_s1, dy_s1;
	logic signed [PROD_W-1:0]         p_dxc_s2, p_dys_s2, p_dyc_s2, p_dxs_s2;
	logic [SUM_W-1:0]                 tx_s3, ty_s3;
	logic [imrot_pkg::ADDR_W-1:0]     addr_s4;
	logic                             out_s4;

	logic [SUM_W-1:0] cxq, cyq, tx_b, ty_b;
	logic [SRC_W-1:0] sx, sy;
	logic [8:0]       w_eff, h_eff;
	logic             in_x, in_y;

	// A stage takes a new beat when it is empty or its contents move on.
	assign en4      = !v_s4 || down_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: offsets from the centre.
	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1 <= cmd;
			row_s1 <= row;
			col_s1 <= col;
			pix_s1 <= pixel_in;
			dx_s1  <= $signed({4'd0, col}) - $signed({cfg.centre_x[10], cfg.centre_x});
			dy_s1  <= $signed({4'd0, row}) - $signed({cfg.centre_y[10], cfg.centre_y});
		end
	end

	// Stage 2: the four rotation products.
	always_ff @(posedge clk) begin
		if (en2) begin
			cmd_s2   <= cmd_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			pix_s2   <= pix_s1;
			p_dxc_s2 <= dx_s1 * $signed(cfg.cosine_q14);
			p_dys_s2 <= dy_s1 * $signed(cfg.sine_q14);
			p_dyc_s2 <= dy_s1 * $signed(cfg.cosine_q14);
			p_dxs_s2 <= dx_s1 * $signed(cfg.sine_q14);
		end
	end

	assign cxq = {{(SUM_W - 11 - imrot_pkg::Q_FRAC){cfg.centre_x[10]}}, cfg.centre_x,
		{imrot_pkg::Q_FRAC{1'b0}}};
	assign cyq = {{(SUM_W - 11 - imrot_pkg::Q_FRAC){cfg.centre_y[10]}}, cfg.centre_y,
		{imrot_pkg::Q_FRAC{1'b0}}};

	// Stage 3: source coordinates in Q14.
	always_ff @(posedge clk) begin
		if (en3) begin
			cmd_s3 <= cmd_s2;
			row_s3 <= row_s2;
			col_s3 <= col_s2;
			pix_s3 <= pix_s2;
			tx_s3  <= {p_dxc_s2[PROD_W-1], p_dxc_s2} - {p_dys_s2[PROD_W-1], p_dys_s2} + cxq;
			ty_s3  <= {p_dyc_s2[PROD_W-1], p_dyc_s2} + {p_dxs_s2[PROD_W-1], p_dxs_s2} + cyq;
		end
	end

	// Negative values get a bias of one less than 1.0 so the arithmetic shift
	// truncates toward zero instead of toward minus infinity.
	assign tx_b = tx_s3 + (tx_s3[SUM_W-1] ? SUM_W'((1 << imrot_pkg::Q_FRAC) - 1) : '0);
	assign ty_b = ty_s3 + (ty_s3[SUM_W-1] ? SUM_W'((1 << imrot_pkg::Q_FRAC) - 1) : '0);
	assign sx   = tx_b[SUM_W-1:imrot_pkg::Q_FRAC];
	assign sy   = ty_b[SUM_W-1:imrot_pkg::Q_FRAC];

	// Sizes above the store clamp to the store; bit 8 set means at least 256.
	assign w_eff = cfg.image_width[8]  ? 9'(imrot_pkg::MAX_WIDTH)  : cfg.image_width;
	assign h_eff = cfg.image_height[8] ? 9'(imrot_pkg::MAX_HEIGHT) : cfg.image_height;
	assign in_x  = !sx[SRC_W-1] && (sx[SRC_W-2:0] < {{(SRC_W - 10){1'b0}}, w_eff});
	assign in_y  = !sy[SRC_W-1] && (sy[SRC_W-2:0] < {{(SRC_W - 10){1'b0}}, h_eff});

	// Stage 4: range check and store address.
	always_ff @(posedge clk) begin
		if (en4) begin
			cmd_s4 <= cmd_s3;
			pix_s4 <= pix_s3;
			out_s4 <= !(in_x && in_y);
			if (cmd_s3 == imrot_pkg::CMD_WRITE) begin
				addr_s4 <= {row_s3, col_s3};
			end else begin
				addr_s4 <= {sy[imrot_pkg::ROW_W-1:0], sx[imrot_pkg::COL_W-1:0]};
			end
		end
	end

	assign req_valid   = v_s4;
	assign req.cmd     = cmd_s4;
	assign req.addr    = addr_s4;
	assign req.outside = out_s4;
	assign req.pixel   = pix_s4;

endmodule

// ----- rtl/imrot_store.sv -----
// Pixel store: one write port and one read port with registered read data.
// Depends on imrot_pkg for depth and widths.

module imrot_store (
	input  logic                             clk,
	input  logic                             we,
	input  logic [imrot_pkg::ADDR_W-1:0]     waddr,
	input  logic [imrot_pkg::PIXEL_BITS-1:0] wdata,
	input  logic                             re,
	input  logic [imrot_pkg::ADDR_W-1:0]     raddr,
	output logic [imrot_pkg::PIXEL_BITS-1:0] rdata
);

	logic [imrot_pkg::PIXEL_BITS-1:0] mem [imrot_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while re is low, so a stalled result stays put.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/image_rotate_about_point.sv -----
// Nearest-neighbor image rotation about a point: top level.
// Holds the register file, the output stage and instances of imrot_coord and imrot_store.
//
// Usage:
//   Input channel (in_valid/in_ready) carries cmd, row, col and pixel_in. A beat with
//   cmd write stores pixel_in at (row, col) and produces no result. A beat with cmd
//   read maps (row, col) back through the rotation and produces one result beat.
//   Output channel (out_valid/out_ready) carries pixel_out and outside.
//   A read result is registered through offsets, products, sums, range check and store
//   read, in that order. Throughput is one beat per cycle while out_ready is high; the
//   store's single read port and single write port set that figure.
//   Writes and reads pass the store in input order, so a read sees every earlier write.
//   Registers must be written via the APB port only while the block is idle; not enforced.
//   Reset restores the register defaults and empties the pipeline; the pixel store is
//   not cleared, and reading a location never written returns an unspecified value.
//   When out_ready is low, the result beat holds and stages behind it keep filling
//   until every stage is occupied, after which in_ready falls.

module image_rotate_about_point (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [4:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic [7:0]                       row,
	input  logic [7:0]                       col,
	input  logic [imrot_pkg::PIXEL_BITS-1:0] pixel_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [imrot_pkg::PIXEL_BITS-1:0] pixel_out,
	output logic                             outside
);

	imrot_pkg::cfg_t       cfg_q;
	imrot_pkg::store_req_t req;
	logic                  req_valid;
	logic                  en5;
	logic                  v_s5;
	logic                  out_s5;
	logic                  cfg_wr;
	logic [2:0]            reg_idx;
	logic                  st_we, st_re;
	logic [imrot_pkg::PIXEL_BITS-1:0] rdata;
	logic [imrot_pkg::PIXEL_BITS-1:0] byte_mask;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= 9'd256;
			cfg_q.image_height    <= 9'd256;
			cfg_q.centre_x        <= 11'd0;
			cfg_q.centre_y        <= 11'd0;
			cfg_q.cosine_q14      <= 16'd16384;
			cfg_q.sine_q14        <= 16'd0;
			cfg_q.bytes_per_pixel <= 3'd1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				imrot_pkg::REG_IMAGE_WIDTH:     cfg_q.image_width     <= pwdata[8:0];
				imrot_pkg::REG_IMAGE_HEIGHT:    cfg_q.image_height    <= pwdata[8:0];
				imrot_pkg::REG_CENTRE_X:        cfg_q.centre_x        <= pwdata[10:0];
				imrot_pkg::REG_CENTRE_Y:        cfg_q.centre_y        <= pwdata[10:0];
				imrot_pkg::REG_COSINE_Q14:      cfg_q.cosine_q14      <= pwdata[15:0];
				imrot_pkg::REG_SINE_Q14:        cfg_q.sine_q14        <= pwdata[15:0];
				imrot_pkg::REG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			imrot_pkg::REG_IMAGE_WIDTH:     prdata = {23'd0, cfg_q.image_width};
			imrot_pkg::REG_IMAGE_HEIGHT:    prdata = {23'd0, cfg_q.image_height};
			imrot_pkg::REG_CENTRE_X:        prdata = {21'd0, cfg_q.centre_x};
			imrot_pkg::REG_CENTRE_Y:        prdata = {21'd0, cfg_q.centre_y};
			imrot_pkg::REG_COSINE_Q14:      prdata = {16'd0, cfg_q.cosine_q14};
			imrot_pkg::REG_SINE_Q14:        prdata = {16'd0, cfg_q.sine_q14};
			imrot_pkg::REG_BYTES_PER_PIXEL: prdata = {29'd0, cfg_q.bytes_per_pixel};
			default:                        prdata = 32'd0;
		endcase
	end

	imrot_coord u_coord (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.row        (row),
		.col        (col),
		.pixel_in   (pixel_in),
		.down_ready (en5),
		.req_valid  (req_valid),
		.req        (req)
	);

	// Stage 5 is the store access. A write leaves a bubble behind it.
	assign en5   = !v_s5 || out_ready;
	assign st_we = en5 && req_valid && (req.cmd == imrot_pkg::CMD_WRITE);
	assign st_re = en5 && req_valid && (req.cmd == imrot_pkg::CMD_READ);

	imrot_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (req.addr),
		.wdata (req.pixel),
		.re    (st_re),
		.raddr (req.addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= req_valid && (req.cmd == imrot_pkg::CMD_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (st_re) begin
			out_s5 <= req.outside;
		end
	end

	// A byte count of zero acts as one and counts above four act as four.
	always_comb begin
		case (cfg_q.bytes_per_pixel)
			3'd0, 3'd1: byte_mask = 32'h0000_00FF;
			3'd2:       byte_mask = 32'h0000_FFFF;
			3'd3:       byte_mask = 32'h00FF_FFFF;
			default:    byte_mask = 32'hFFFF_FFFF;
		endcase
	end

	assign out_valid = v_s5;
	assign outside   = out_s5;
	assign pixel_out = out_s5 ? '0 : (rdata & byte_mask);

endmodule
